>>> design/pfe_pkg.sv
// Shared types and constants for the Playfair encryption block.
`timescale 1ns / 1ps
package pfe_pkg;

	localparam int SIDE    = 5;
	localparam int CELLS   = 25;
	localparam int LETTERS = 26;

	localparam logic [2:0] MODE_CLEAR   = 3'd0;
	localparam logic [2:0] MODE_KEY     = 3'd1;
	localparam logic [2:0] MODE_KEY_END = 3'd2;
	localparam logic [2:0] MODE_PLAIN   = 3'd3;
	localparam logic [2:0] MODE_MSG_END = 3'd4;

	localparam logic [4:0] PAD_LETTER = 5'd23;

	// alphabet without q, used to complete the square
	localparam logic [4:0] FILL_ALPHA [CELLS] = '{
		5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
		5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd17, 5'd18, 5'd19,
		5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25
	};

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] letter;
	} in_item_t;

	typedef struct packed {
		logic [4:0] cipher_first;
		logic [4:0] cipher_second;
		logic       not_in_square;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic place_in;
		logic fill_start;
		logic fill_step;
		logic pend_load;
		logic pair_start;
		logic pair_pad;
		logic pend_drop;
		logic rd_a;
		logic rd_b;
		logic rd_na;
		logic rd_nb;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pend_valid;
		logic pend_match;
		logic fill_done;
		logic miss;
		logic out_free;
	} sts_t;

endpackage

>>> design/playfair_cipher_encrypt_top.sv
// Top level of the Playfair encryption block.
// Input channel plain_*: one item per transfer, mode plus letter code 0..25.
//   Mode 0 clears the key, 1 adds a key letter, 2 ends the key and completes the
//   square, 3 is a plaintext letter, 4 ends the message.
// Output channel cipher_*: one encrypted pair per transfer, with a flag when a
//   letter of the pair is not in the square (letters then pass unchanged).
// Sequence: clear, key letter and the first letter of a pair are done in the idle state.
//   Key end walks the 25-letter fill alphabet one letter per cycle, and the item
//   holds the input until the fill is done.
//   A pair needs two position-map reads and two square reads, one per cycle on
//   single-port stores, in states RDA, RDB, CALC and RDNB; the result is loaded into
//   the output register in state OUT (RDA then OUT when a letter is not in the
//   square). plain_stall is high while an item is in work.
// The output register frees the sequencer: the next item is taken while a
//   result waits; a further pair waits only if the receiver still stalls.
// Reset clears the key, fill count, pending letter and output valid; the square
//   holds no data until a key is entered.
`timescale 1ns / 1ps
module playfair_cipher_encrypt_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               plain_valid,
	output logic               plain_stall,
	input  pfe_pkg::in_item_t  plain_data,
	output logic               cipher_valid,
	input  logic               cipher_stall,
	output pfe_pkg::out_item_t cipher_data
);
	import pfe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pfe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.plain_valid (plain_valid),
		.plain_stall (plain_stall),
		.plain_data  (plain_data),
		.sts         (sts),
		.cmd         (cmd)
	);

	pfe_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.plain_data   (plain_data),
		.cmd          (cmd),
		.sts          (sts),
		.cipher_valid (cipher_valid),
		.cipher_stall (cipher_stall),
		.cipher_data  (cipher_data)
	);

endmodule

>>> design/pfe_ctrl.sv
// Sequencer for the Playfair block: decodes modes and steps key fill and pair lookup.
`timescale 1ns / 1ps
module pfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              plain_valid,
	output logic              plain_stall,
	input  pfe_pkg::in_item_t plain_data,
	input  pfe_pkg::sts_t     sts,
	output pfe_pkg::cmd_t     cmd
);
	import pfe_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_FILL = 7'b0000010,
		S_RDA  = 7'b0000100,
		S_RDB  = 7'b0001000,
		S_CALC = 7'b0010000,
		S_RDNB = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign plain_stall = (state_q != S_IDLE);
	assign take        = plain_valid && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (plain_data.mode)
						MODE_CLEAR: cmd.clear = 1'b1;
						MODE_KEY: cmd.place_in = 1'b1;
						MODE_KEY_END: begin
							cmd.fill_start = 1'b1;
							state_d        = S_FILL;
						end
						MODE_PLAIN: begin
							if (!sts.pend_valid) begin
								cmd.pend_load = 1'b1;
							end else begin
								// doubled letter keeps itself pending, paired with x
								cmd.pair_start = 1'b1;
								cmd.pair_pad   = sts.pend_match;
								cmd.pend_drop  = !sts.pend_match;
								state_d        = S_RDA;
							end
						end
						MODE_MSG_END: begin
							if (sts.pend_valid) begin
								cmd.pair_start = 1'b1;
								cmd.pair_pad   = 1'b1;
								cmd.pend_drop  = 1'b1;
								state_d        = S_RDA;
							end
						end
						default: ;
					endcase
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_done) state_d = S_IDLE;
			end
			S_RDA: begin
				if (sts.miss) begin
					state_d = S_OUT;
				end else begin
					cmd.rd_a = 1'b1;
					state_d  = S_RDB;
				end
			end
			S_RDB: begin
				cmd.rd_b = 1'b1;
				state_d  = S_CALC;
			end
			S_CALC: begin
				cmd.rd_na = 1'b1;
				state_d   = S_RDNB;
			end
			S_RDNB: begin
				cmd.rd_nb = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/pfe_dp.sv
// Datapath for the Playfair block: key square, position map, pair rule, output register.
`timescale 1ns / 1ps
module pfe_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pfe_pkg::in_item_t  plain_data,
	input  pfe_pkg::cmd_t      cmd,
	output pfe_pkg::sts_t      sts,
	output logic               cipher_valid,
	input  logic               cipher_stall,
	output pfe_pkg::out_item_t cipher_data
);
	import pfe_pkg::*;

	// square cells and, per letter, its row and column
	logic [4:0] sq_mem  [CELLS];
	logic [5:0] pos_mem [LETTERS];

	logic [LETTERS-1:0] used_q;
	logic [4:0]         fill_q;
	logic [2:0]         frow_q, fcol_q;
	logic [4:0]         idx_q;
	logic               pend_v_q;
	logic [4:0]         pend_q;
	logic [4:0]         a_q, b_q;
	logic [5:0]         pos_rd_q, pa_q;
	logic [4:0]         sq_rd_q, first_q, nb_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic [4:0] pl_c;
	logic       place_en;
	logic       a_in, b_in;
	logic [4:0] pos_addr;
	logic [2:0] r0, c0, r1, c1, r0n, c0n, r1n, c1n;
	logic [2:0] nar, nac, nbr, nbc;
	logic [4:0] na, nb;

	function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
		logic [4:0] rr;
		rr = {2'b00, r};
		return (rr << 2) + rr + {2'b00, c};
	endfunction

	function automatic logic [2:0] wrap_inc(input logic [2:0] v);
		return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
	endfunction

	assign pl_c     = cmd.fill_step ? FILL_ALPHA[idx_q] : plain_data.letter;
	assign place_en = (cmd.place_in || cmd.fill_step) && (pl_c < 5'(LETTERS))
		&& (fill_q < 5'(CELLS)) && !used_q[pl_c];

	assign a_in = (a_q < 5'(LETTERS)) ? used_q[a_q] : 1'b0;
	assign b_in = (b_q < 5'(LETTERS)) ? used_q[b_q] : 1'b0;

	always_comb begin
		pos_addr = cmd.rd_a ? a_q : b_q;
		if (pos_addr >= 5'(LETTERS)) pos_addr = '0;
	end

	// pair rule
	assign r0  = pa_q[5:3];
	assign c0  = pa_q[2:0];
	assign r1  = pos_rd_q[5:3];
	assign c1  = pos_rd_q[2:0];
	assign r0n = wrap_inc(r0);
	assign c0n = wrap_inc(c0);
	assign r1n = wrap_inc(r1);
	assign c1n = wrap_inc(c1);

	always_comb begin
		if (r0 == r1) begin
			nar = r0;  nac = c0n;
			nbr = r1;  nbc = c1n;
		end else if (c0 == c1) begin
			nar = r0n; nac = c0;
			nbr = r1n; nbc = c1;
		end else begin
			nar = r0;  nac = c1;
			nbr = r1;  nbc = c0;
		end
	end

	assign na = cell_of(nar, nac);
	assign nb = cell_of(nbr, nbc);

	always_ff @(posedge clk) begin
		if (place_en) begin
			sq_mem[fill_q] <= pl_c;
			pos_mem[pl_c]  <= {frow_q, fcol_q};
		end
		if (cmd.rd_a || cmd.rd_b) pos_rd_q <= pos_mem[pos_addr];
		if (cmd.rd_na) sq_rd_q <= sq_mem[na];
		else if (cmd.rd_nb) sq_rd_q <= sq_mem[nb_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.pair_start) begin
			a_q <= pend_q;
			b_q <= cmd.pair_pad ? PAD_LETTER : plain_data.letter;
		end
		if (cmd.rd_b) pa_q <= pos_rd_q;
		if (cmd.rd_na) nb_q <= nb;
		if (cmd.rd_nb) first_q <= sq_rd_q;
		if (cmd.out_load) begin
			if (!(a_in && b_in)) begin
				out_data_q <= '{cipher_first: a_q, cipher_second: b_q, not_in_square: 1'b1};
			end else begin
				out_data_q <= '{cipher_first: first_q, cipher_second: sq_rd_q,
					not_in_square: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			fill_q      <= '0;
			frow_q      <= '0;
			fcol_q      <= '0;
			idx_q       <= '0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				used_q <= '0;
				fill_q <= '0;
				frow_q <= '0;
				fcol_q <= '0;
			end else if (place_en) begin
				used_q[pl_c] <= 1'b1;
				fill_q       <= fill_q + 5'd1;
				if (fcol_q == 3'(SIDE - 1)) begin
					fcol_q <= '0;
					frow_q <= frow_q + 3'd1;
				end else begin
					fcol_q <= fcol_q + 3'd1;
				end
			end
			if (cmd.fill_start) idx_q <= '0;
			else if (cmd.fill_step) idx_q <= idx_q + 5'd1;
			if (cmd.clear || cmd.fill_start) begin
				pend_v_q <= 1'b0;
				pend_q   <= '0;
			end else if (cmd.pend_load) begin
				pend_v_q <= 1'b1;
				pend_q   <= plain_data.letter;
			end else if (cmd.pend_drop) begin
				pend_v_q <= 1'b0;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!cipher_stall) out_valid_q <= 1'b0;
		end
	end

	assign sts.pend_valid = pend_v_q;
	assign sts.pend_match = (plain_data.letter == pend_q);
	assign sts.fill_done  = (idx_q == 5'(CELLS - 1)) || (fill_q >= 5'(CELLS));
	assign sts.miss       = !(a_in && b_in);
	assign sts.out_free   = !out_valid_q || !cipher_stall;

	assign cipher_valid = out_valid_q;
	assign cipher_data  = out_data_q;

endmodule
